// ----- rtl/lmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared constants and types of the letter modular exponentiation cipher.
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int MOD_WIDTH_DEF = 16;
	localparam int EXP_BITS      = 16;
	localparam int CHAR_W        = 8;
	localparam int CFG_W         = 16;
	localparam int IDX_W         = 2;
	localparam int LETTER_W      = 5;
	localparam int FIFO_DEPTH    = 2;

	localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ENC_EXP = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEC_EXP = 2'd2;

	localparam int                MODULUS_RST = 33;
	localparam logic [CFG_W-1:0]  ENC_EXP_RST = 16'd7;
	localparam logic [CFG_W-1:0]  DEC_EXP_RST = 16'd3;

	localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'd64;
	localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd96;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

	localparam logic OP_ENCRYPT = 1'b0;

	typedef struct packed {
		logic letter;
		logic upper;
	} lmc_kind_t;

endpackage

// ----- rtl/lmc_front.sv -----
// ----------------------------------------------------------------------------
// lmc_front
// Classifies a character, picks the exponent and reduces the letter value
// modulo the modulus to seed the exponentiation.
// ----------------------------------------------------------------------------
module lmc_front #(
	parameter int MOD_WIDTH = lmc_pkg::MOD_WIDTH_DEF
) (
	input  logic                        op,
	input  logic [lmc_pkg::CHAR_W-1:0]  in_char,
	input  logic [MOD_WIDTH-1:0]        modulus,
	input  logic [lmc_pkg::CFG_W-1:0]   enc_exponent,
	input  logic [lmc_pkg::CFG_W-1:0]   dec_exponent,
	output lmc_pkg::lmc_kind_t          kind,
	output logic [MOD_WIDTH-1:0]        base,
	output logic [MOD_WIDTH-1:0]        acc_init,
	output logic [lmc_pkg::EXP_BITS-1:0] expo
);

	localparam int RW = MOD_WIDTH + lmc_pkg::LETTER_W;

	logic [lmc_pkg::CHAR_W-1:0] offset;
	logic [lmc_pkg::CHAR_W-1:0] diff;
	logic [RW-1:0]              rem;
	logic [RW-1:0]              msh;

	always_comb begin
		kind.upper  = (in_char >= lmc_pkg::CHAR_UPPER_A) && (in_char <= lmc_pkg::CHAR_UPPER_Z);
		kind.letter = kind.upper ||
			((in_char >= lmc_pkg::CHAR_LOWER_A) && (in_char <= lmc_pkg::CHAR_LOWER_Z));
		offset = kind.upper ? lmc_pkg::UPPER_OFFSET : lmc_pkg::LOWER_OFFSET;
		diff   = in_char - offset;
	end

	// letter value mod modulus, one restoring step per bit of the letter value
	always_comb begin
		rem = RW'(diff[lmc_pkg::LETTER_W-1:0]);
		msh = '0;
		for (int k = lmc_pkg::LETTER_W - 1; k >= 0; k--) begin
			msh = RW'(modulus) << k;
			if (rem >= msh) begin
				rem = rem - msh;
			end
		end
	end

	assign base     = rem[MOD_WIDTH-1:0];
	assign acc_init = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
	assign expo     = (op == lmc_pkg::OP_ENCRYPT) ? enc_exponent : dec_exponent;

endmodule

// ----- rtl/lmc_fifo.sv -----
// ----------------------------------------------------------------------------
// lmc_fifo
// Short queue between the classifying front and the exponentiation pipeline.
// ----------------------------------------------------------------------------
module lmc_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          empty,
	output logic          full
);

	localparam int DEPTH = lmc_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DW-1:0]    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow transfer");

endmodule

// ----- rtl/lmc_back.sv -----
// ----------------------------------------------------------------------------
// lmc_back
// Pipelined square-and-multiply: per exponent bit one multiply stage and
// MOD_WIDTH restoring reduction stages, then the output register.
// ----------------------------------------------------------------------------
module lmc_back #(
	parameter int MOD_WIDTH = lmc_pkg::MOD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  lmc_pkg::lmc_kind_t           head_kind,
	input  logic [MOD_WIDTH-1:0]         head_base,
	input  logic [MOD_WIDTH-1:0]         head_acc,
	input  logic [lmc_pkg::EXP_BITS-1:0] head_expo,
	input  logic [lmc_pkg::CHAR_W-1:0]   head_char,
	input  logic [MOD_WIDTH-1:0]         modulus,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lmc_pkg::CHAR_W-1:0]   out_char
);

	localparam int SUB = MOD_WIDTH + 1;
	localparam int NS  = lmc_pkg::EXP_BITS * SUB;
	localparam int PW  = 2 * MOD_WIDTH;

	logic                         v_q  [NS];
	logic [PW-1:0]                pa_q [NS];
	logic [PW-1:0]                ps_q [NS];
	logic [lmc_pkg::EXP_BITS-1:0] ex_q [NS];
	lmc_pkg::lmc_kind_t           kd_q [NS];
	logic [lmc_pkg::CHAR_W-1:0]   ch_q [NS];

	logic                       adv;
	logic                       out_valid_q;
	logic [lmc_pkg::CHAR_W-1:0] out_char_q;
	logic [lmc_pkg::CHAR_W-1:0] offset;
	logic [lmc_pkg::CHAR_W-1:0] res;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid;

	for (genvar s = 0; s < NS; s++) begin : g_stage
		localparam int IT = s / SUB;
		localparam int SB = s % SUB;

		logic                         pv;
		logic [PW-1:0]                pa_in;
		logic [PW-1:0]                ps_in;
		logic [lmc_pkg::EXP_BITS-1:0] ex_in;
		lmc_pkg::lmc_kind_t           kd_in;
		logic [lmc_pkg::CHAR_W-1:0]   ch_in;
		logic [PW-1:0]                na;
		logic [PW-1:0]                nsq;

		if (s == 0) begin : g_head
			assign pv    = head_valid;
			assign pa_in = PW'(head_acc);
			assign ps_in = PW'(head_base);
			assign ex_in = head_expo;
			assign kd_in = head_kind;
			assign ch_in = head_char;
		end else begin : g_prev
			assign pv    = v_q[s-1];
			assign pa_in = pa_q[s-1];
			assign ps_in = ps_q[s-1];
			assign ex_in = ex_q[s-1];
			assign kd_in = kd_q[s-1];
			assign ch_in = ch_q[s-1];
		end

		if (SB == 0) begin : g_mul
			logic [PW-1:0] a;
			logic [PW-1:0] b;
			assign a   = PW'(pa_in[MOD_WIDTH-1:0]);
			assign b   = PW'(ps_in[MOD_WIDTH-1:0]);
			assign na  = ex_in[IT] ? a * b : a;
			assign nsq = b * b;
		end else begin : g_red
			localparam int K = MOD_WIDTH - SB;
			logic [PW-1:0] ms;
			assign ms  = PW'(modulus) << K;
			assign na  = (pa_in >= ms) ? pa_in - ms : pa_in;
			assign nsq = (ps_in >= ms) ? ps_in - ms : ps_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[s] <= 1'b0;
			end else if (adv) begin
				v_q[s] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pa_q[s] <= na;
				ps_q[s] <= nsq;
				ex_q[s] <= ex_in;
				kd_q[s] <= kd_in;
				ch_q[s] <= ch_in;
			end
		end
	end

	always_comb begin
		offset = kd_q[NS-1].upper ? lmc_pkg::UPPER_OFFSET : lmc_pkg::LOWER_OFFSET;
		if (!kd_q[NS-1].letter) begin
			res = ch_q[NS-1];
		end else if (modulus == '0) begin
			res = offset;
		end else begin
			res = pa_q[NS-1][lmc_pkg::CHAR_W-1:0] + offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NS-1] && !adv |=> v_q[NS-1])
		else $error("last stage lost an item during stall");

endmodule

// ----- rtl/letter_modexp_cipher.sv -----
// ----------------------------------------------------------------------------
// letter_modexp_cipher
// Letter cipher: upper or lower case letters are mapped to 1..26, raised to
// the encrypt or decrypt exponent modulo the modulus and shifted back; other
// bytes pass unchanged.
//
// Usage:
//   input channel  in_valid/in_ready with op and in_char, one transfer each
//   output channel out_valid/out_ready with out_char, one result per input
//   config channel cfg_valid/cfg_ready (always ready), cfg_index selects
//   modulus (0), enc_exponent (1), dec_exponent (2); other indexes ignored
//   write config only while no item is in flight
// Throughput: one character per cycle while out_ready stays high.
// Path: from input transfer to out_valid an item passes the queue, one
//   multiply stage plus MOD_WIDTH reduction stages per exponent bit, and the
//   output register.
// Reset: registers return to modulus 33, enc_exponent 7, dec_exponent 3,
//   pipeline and queue empty.
// Stall: when out_valid is high and out_ready is low the whole pipeline holds;
//   the queue keeps taking characters until it is full, then in_ready drops.
// ----------------------------------------------------------------------------
module letter_modexp_cipher #(
	parameter int MOD_WIDTH = lmc_pkg::MOD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [lmc_pkg::CHAR_W-1:0] in_char,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lmc_pkg::CHAR_W-1:0] out_char,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lmc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [lmc_pkg::CFG_W-1:0]  cfg_data
);

	localparam int EB = lmc_pkg::EXP_BITS;
	localparam int CW = lmc_pkg::CHAR_W;
	localparam int DW = 2 + 2 * MOD_WIDTH + EB + CW;

	logic [MOD_WIDTH-1:0]      modulus_q;
	logic [lmc_pkg::CFG_W-1:0] enc_exp_q;
	logic [lmc_pkg::CFG_W-1:0] dec_exp_q;

	lmc_pkg::lmc_kind_t   f_kind;
	logic [MOD_WIDTH-1:0] f_base;
	logic [MOD_WIDTH-1:0] f_acc;
	logic [EB-1:0]        f_expo;

	logic          push;
	logic          pop;
	logic          empty;
	logic          full;
	logic [DW-1:0] q_din;
	logic [DW-1:0] q_dout;

	lmc_pkg::lmc_kind_t   h_kind;
	logic [MOD_WIDTH-1:0] h_base;
	logic [MOD_WIDTH-1:0] h_acc;
	logic [EB-1:0]        h_expo;
	logic [CW-1:0]        h_char;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_WIDTH'(lmc_pkg::MODULUS_RST);
			enc_exp_q <= lmc_pkg::ENC_EXP_RST;
			dec_exp_q <= lmc_pkg::DEC_EXP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lmc_pkg::REG_MODULUS: modulus_q <= MOD_WIDTH'(cfg_data);
				lmc_pkg::REG_ENC_EXP: enc_exp_q <= cfg_data;
				lmc_pkg::REG_DEC_EXP: dec_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lmc_front #(.MOD_WIDTH(MOD_WIDTH)) u_front (
		.op           (op),
		.in_char      (in_char),
		.modulus      (modulus_q),
		.enc_exponent (enc_exp_q),
		.dec_exponent (dec_exp_q),
		.kind         (f_kind),
		.base         (f_base),
		.acc_init     (f_acc),
		.expo         (f_expo)
	);

	assign in_ready = !full;
	assign push     = in_valid && !full;
	assign q_din    = {f_kind, f_base, f_acc, f_expo, in_char};

	lmc_fifo #(.DW(DW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (empty),
		.full   (full)
	);

	assign {h_kind, h_base, h_acc, h_expo, h_char} = q_dout;

	lmc_back #(.MOD_WIDTH(MOD_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!empty),
		.head_kind  (h_kind),
		.head_base  (h_base),
		.head_acc   (h_acc),
		.head_expo  (h_expo),
		.head_char  (h_char),
		.modulus    (modulus_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char)
	);

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the letter modular exponentiation cipher: a directed
// table, key extremes, then random characters under several handshake idle
// mixes, each output checked against the table or a square-and-multiply
// predictor; config rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import lmc_pkg::*;

	localparam int LATENCY   = 16 * (MOD_WIDTH_DEF + 1) + 1;
	localparam int CYC_LIMIT = 900000;

	typedef struct {
		logic             op;
		logic [CHAR_W-1:0] ch;
		logic             has_exp;
		logic [CHAR_W-1:0] exp_char;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = 1'b0;
	logic [CHAR_W-1:0] in_char = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	logic [CFG_W-1:0] key_mod, key_enc, key_dec;
	logic [CHAR_W-1:0] cipher_q[$];
	int               mismatches = 0;
	int               results_seen = 0;
	int               cycles = 0;
	int               send_idle = 0;
	int               recv_stall = 0;

	letter_modexp_cipher dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [CHAR_W-1:0] cipher_char(logic o, logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] offs;
		logic [63:0]       acc, sq, m;
		logic [CFG_W-1:0]  e;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) offs = UPPER_OFFSET;
		else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) offs = LOWER_OFFSET;
		else return c;
		e = (o == OP_ENCRYPT) ? key_enc : key_dec;
		m = key_mod;
		if (m == 0) acc = 0;
		else begin
			acc = 1 % m;
			sq = (c - offs) % m;
			for (int i = 0; i < EXP_BITS; i++) begin
				if (e[i]) acc = (acc * sq) % m;
				sq = (sq * sq) % m;
			end
		end
		return CHAR_W'(acc + offs);
	endfunction

	task automatic report(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
		$display("mismatch %s: out_char %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// receiver side: stall at random, check every transfer
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (cipher_q.size() == 0) report("unexpected", out_char, '0);
			else begin
				logic [CHAR_W-1:0] want;
				want = cipher_q.pop_front();
				if (out_char !== want) report("out_char", out_char, want);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MODULUS) key_mod = val;
		else if (idx == REG_ENC_EXP) key_enc = val;
		else if (idx == REG_DEC_EXP) key_dec = val;
	endtask

	task automatic send_char(logic o, logic [CHAR_W-1:0] c, logic has_exp, logic [CHAR_W-1:0] e);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op       <= o;
		in_char  <= c;
		in_valid <= 1'b1;
		cipher_q.push_back(has_exp ? e : cipher_char(o, c));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_char();
		case ($urandom_range(3))
			0: return CHAR_UPPER_A + CHAR_W'($urandom_range(25));
			1: return CHAR_LOWER_A + CHAR_W'($urandom_range(25));
			default: return CHAR_W'($urandom_range(255));
		endcase
	endfunction

	stim_row_t directed[16] = '{
		'{1'b0, 8'h00, 1'b1, 8'h00},
		'{1'b1, 8'hFF, 1'b1, 8'hFF},
		'{1'b0, 8'h40, 1'b1, 8'h40},
		'{1'b0, 8'h5B, 1'b1, 8'h5B},
		'{1'b0, 8'h60, 1'b1, 8'h60},
		'{1'b1, 8'h7B, 1'b1, 8'h7B},
		'{1'b0, 8'h41, 1'b1, 8'h41},
		'{1'b1, 8'h61, 1'b1, 8'h61},
		'{1'b0, 8'h5A, 1'b0, 8'h00},
		'{1'b1, 8'h5A, 1'b0, 8'h00},
		'{1'b0, 8'h7A, 1'b0, 8'h00},
		'{1'b1, 8'h7A, 1'b0, 8'h00},
		'{1'b0, 8'h48, 1'b0, 8'h00},
		'{1'b1, 8'h6D, 1'b0, 8'h00},
		'{1'b0, 8'hC1, 1'b1, 8'hC1},
		'{1'b1, 8'h80, 1'b1, 8'h80}
	};

	// modulus, enc exponent, dec exponent per phase
	logic [CFG_W-1:0] settings[6][3] = '{
		'{16'd33, 16'd7, 16'd3},
		'{16'd65535, 16'd65535, 16'd0},
		'{16'd2, 16'd0, 16'd65535},
		'{16'd0, 16'd5, 16'd9},
		'{16'd1, 16'd1, 16'd1},
		'{16'd3233, 16'd17, 16'd2753}
	};

	int idle_mix[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{15, 15}};

	initial begin
		key_mod = CFG_W'(MODULUS_RST);
		key_enc = ENC_EXP_RST;
		key_dec = DEC_EXP_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_char(directed[i].op, directed[i].ch, directed[i].has_exp, directed[i].exp_char);
		drain();
		// zero exponent and modulus zero / one extremes with letters
		for (int p = 1; p < 5; p++) begin
			for (int r = 0; r < 3; r++) write_reg(IDX_W'(r), settings[p][r]);
			write_reg(2'd3, CFG_W'($urandom));
			for (int k = 0; k < 8; k++)
				send_char(k[0], k[1] ? CHAR_UPPER_Z : CHAR_LOWER_A, 1'b0, '0);
			drain();
		end
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) for (int r = 0; r < 3; r++) write_reg(IDX_W'(r), settings[ph][r]);
			else begin
				write_reg(REG_MODULUS, ($urandom_range(3) == 0) ?
					CFG_W'($urandom) : CFG_W'($urandom_range(2, 300)));
				write_reg(REG_ENC_EXP, CFG_W'($urandom));
				write_reg(REG_DEC_EXP, CFG_W'($urandom));
			end
			send_idle  = idle_mix[ph % 4][0];
			recv_stall = idle_mix[ph % 4][1];
			repeat (220) send_char(1'($urandom_range(1)), random_char(), 1'b0, '0);
			drain();
		end
		$display("covered %0d checked results over directed extremes and 8 random key phases",
			results_seen);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
